// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication that must hold every cycle outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;
    localparam int QueueDepth = 4;
    localparam logic [7:0] PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } core_state_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// File: hdl/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if import sha_pkg::*;;
    logic    valid;
    logic    ready;
    in_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if import sha_pkg::*;;
    logic     valid;
    logic     ready;
    out_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/sha_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_queue import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  in_req_t push_data,
    output logic    full,
    input  logic    pop,
    output in_req_t pop_data,
    output logic    empty
);
    localparam int AW = $clog2(QueueDepth);
    in_req_t          mem_reg [QueueDepth];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;

    assign full     = (cnt_reg == AW'(0) + (AW+1)'(QueueDepth));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

    `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= (AW+1)'(QueueDepth))
    `ASSERT_NEXT(a_push_only, push && !full && !pop, !empty)
    `ASSERT_IMPL(a_no_both, full, !empty)
endmodule

// File: hdl/sha_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_core import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_req_t  item,
    output logic     item_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output out_req_t out_data
);
    core_state_t   state_reg, state_next;
    logic [31:0]   blk_reg [16];
    logic [5:0]    fill_reg;
    logic [63:0]   bits_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic [2:0]    idx_reg;
    logic          final_reg;
    logic          mark_reg;
    logic          len_reg;

    logic          take_byte, full_blk, len_fits;
    logic [31:0]   t1, t2, w_new, w_cur;
    logic [31:0]   s0, s1;

    // schedule word for this round
    assign w_cur = w_reg[0];
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;

    // round datapath
    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_const(rnd_reg) + w_cur;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign take_byte = (state_reg == ST_TAKE) && item_valid && item.byte_present;
    assign full_blk  = take_byte && (fill_reg == 6'd63);

    // length fits in this pad block when the marker is already out or leaves room
    assign len_fits = mark_reg || (fill_reg < 6'd56);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_TAKE:
            begin
                if (item_valid)
                begin
                    if (full_blk)
                        state_next = ST_LOAD;
                    else if (item.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:
            begin
                if (final_reg && len_reg)
                    state_next = ST_EMIT;
                else if (final_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_TAKE;
            end
            ST_EMIT:  if (out_ready && idx_reg == 3'd7) state_next = ST_TAKE;
            default:  state_next = ST_TAKE;
        endcase
    end

    // outputs
    always_comb
    begin
        item_pop = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_TAKE: item_pop = item_valid;
            ST_EMIT: out_valid = 1'b1;
            default: item_pop = 1'b0;
        endcase
    end
    assign out_data.digest_word = h_reg[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    // block buffer and schedule window
    always_ff @(posedge clk)
    begin
        if (take_byte)
            blk_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= item.data_byte;
        if (state_reg == ST_PAD)
        begin
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 4; j++)
                begin
                    if (!mark_reg && 6'(4*i + j) == fill_reg)
                        blk_reg[i][8*(3-j) +: 8] <= PadByte;
                    else if (6'(4*i + j) >= fill_reg)
                        blk_reg[i][8*(3-j) +: 8] <= '0;
                end
            // big-endian bit length in the last two words
            if (len_fits)
            begin
                blk_reg[14] <= bits_reg[63:32];
                blk_reg[15] <= bits_reg[31:0];
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk_reg[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
    end

    // control, counters and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg <= '0;
            idx_reg <= '0;
            final_reg <= 1'b0;
            mark_reg <= 1'b0;
            len_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (take_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
                bits_reg <= bits_reg + 64'd8;
            end
            if (state_reg == ST_TAKE && item_valid)
                final_reg <= item.end_of_message;
            if (state_reg == ST_PAD)
            begin
                mark_reg <= 1'b1;
                len_reg <= len_fits;
            end
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_reg + 1'b1;
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                fill_reg <= '0;
            end
            if (state_reg == ST_EMIT && out_ready)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= init_hash(3'(i));
                    bits_reg <= '0;
                    final_reg <= 1'b0;
                    fill_reg <= '0;
                    mark_reg <= 1'b0;
                    len_reg <= 1'b0;
                end
            end
        end
    end

    `ASSERT_IMPL(a_emit_valid, state_reg == ST_EMIT, out_valid && !item_pop)
    `ASSERT_NEXT(a_round_wrap, state_reg == ST_ROUND && rnd_reg == 6'd63, state_reg == ST_ADD)
    `ASSERT_IMPL(a_pop_take, item_pop, state_reg == ST_TAKE)
    `ASSERT_IMPL(a_emit_len, state_reg == ST_EMIT, len_reg && mark_reg)
endmodule

// File: hdl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// channel   dir   payload
// in_ch     in    data_byte, byte_present, end_of_message
// out_ch    out   digest_word, word_index, last_word
// a byte request is taken by the core once it leads the four-entry queue
// a full block then runs through the single round unit (load, 64 rounds, add)
// an end request runs each padded block through (pad, load, 64 rounds, add),
// one or two blocks, then eight output requests of one out_ready handshake each
// the queue keeps taking requests while it is not full, even with the core busy or stalled
// reset loads the initial hash values; no clearing pass is needed
module sha256_stream_hasher_top import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    logic    full, empty, pop;
    in_req_t head;

    assign in_ch.ready = !full;

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_ch.valid), .push_data(in_ch.payload), .full(full),
        .pop(pop), .pop_data(head), .empty(empty)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n),
        .item_valid(!empty), .item(head), .item_pop(pop),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload)
    );
endmodule
